FILE: hdl/pdfr_pkg.sv
// Package for the PWM duty fade ramp: fixed field widths, scaling constants,
// reciprocal constants for the constant divisions, and controller/datapath structs.
// No dependencies.
package pdfr_pkg;

   localparam int TICK_MS    = 10;
   localparam int DUTY_SCALE = 10;

   localparam int DEST_W = 8;
   localparam int TIME_W = 16;

   localparam int DUTY_MAX = (2**DEST_W - 1) * DUTY_SCALE;
   localparam int DUTY_W   = $clog2(DUTY_MAX + 1);
   localparam int STEP_W   = DUTY_W + 1;
   localparam int SUM_W    = DUTY_W + 2;

   localparam int TICKS_MAX = (2**TIME_W - 1) / TICK_MS;
   localparam int TICKS_W   = $clog2(TICKS_MAX + 1);

   localparam int DSC_SH  = DUTY_W + $clog2(DUTY_SCALE);
   localparam int DREC    = (2**DSC_SH + DUTY_SCALE - 1) / DUTY_SCALE;
   localparam int DREC_W  = $clog2(DREC + 1);
   localparam int DPROD_W = DUTY_W + DREC_W;

   localparam int TCK_SH  = TIME_W + $clog2(TICK_MS);
   localparam int TREC    = (2**TCK_SH + TICK_MS - 1) / TICK_MS;
   localparam int TREC_W  = $clog2(TREC + 1);
   localparam int TPROD_W = TIME_W + TREC_W;

   localparam int CNT_W = $clog2(DUTY_W);

   typedef struct packed {
      logic load;
      logic do_tick;
      logic do_eval;
      logic div_step;
      logic do_fin;
      logic out_load;
   } pdfr_cmd_type;

   typedef struct packed {
      logic match;
      logic quick;
   } pdfr_stat_type;

endpackage

FILE: hdl/pdfr_dpath.sv
// Datapath of the PWM duty fade ramp: duty, step and target registers, the
// serial step divider and the result beat registers. Uses pdfr_pkg.
module pdfr_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  pdfr_pkg::pdfr_cmd_type     cmd,
   output pdfr_pkg::pdfr_stat_type    stat,
   input  logic [pdfr_pkg::DEST_W-1:0] req_dest_duty,
   input  logic [pdfr_pkg::TIME_W-1:0] req_fade_time_ms,
   output logic [pdfr_pkg::DEST_W-1:0] rsp_duty_out,
   output logic                       rsp_fading
);

   logic [pdfr_pkg::DUTY_W-1:0]         duty_ff, duty_in;
   logic signed [pdfr_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [pdfr_pkg::DUTY_W-1:0]         target_ff, target_in;
   logic [pdfr_pkg::DUTY_W-1:0]         goal_ff;
   logic [pdfr_pkg::TICKS_W-1:0]        ticks_ff;
   logic                                quick_ff;
   logic                                neg_ff, neg_in;
   logic [pdfr_pkg::DUTY_W-1:0]         dvd_ff, dvd_in;
   logic [pdfr_pkg::TICKS_W-1:0]        rem_ff, rem_in;
   logic [pdfr_pkg::DEST_W-1:0]         duty_out_ff;
   logic                                fading_ff;

   logic [pdfr_pkg::TPROD_W-1:0]        tprod;
   logic [pdfr_pkg::DPROD_W-1:0]        dprod;
   logic [pdfr_pkg::DUTY_W:0]           goal_hi;
   logic signed [pdfr_pkg::SUM_W-1:0]   sum;
   logic signed [pdfr_pkg::SUM_W-1:0]   tgt_s;
   logic                                reached;
   logic [pdfr_pkg::TICKS_W:0]          trial;
   logic                                ge;
   logic [pdfr_pkg::DUTY_W-1:0]         mag;

   assign tprod = pdfr_pkg::TPROD_W'(req_fade_time_ms)
                * pdfr_pkg::TPROD_W'(pdfr_pkg::TREC);
   assign dprod = pdfr_pkg::DPROD_W'(duty_ff) * pdfr_pkg::DPROD_W'(pdfr_pkg::DREC);

   assign goal_hi    = {1'b0, goal_ff} + (pdfr_pkg::DUTY_W+1)'(pdfr_pkg::DUTY_SCALE);
   assign stat.match = (duty_ff >= goal_ff) && ({1'b0, duty_ff} < goal_hi);
   assign stat.quick = quick_ff;

   assign sum = $signed({2'b00, duty_ff})
              + $signed({{(pdfr_pkg::SUM_W-pdfr_pkg::STEP_W){step_ff[pdfr_pkg::STEP_W-1]}},
                         step_ff});
   assign tgt_s   = $signed({2'b00, target_ff});
   assign reached = step_ff[pdfr_pkg::STEP_W-1] ? (sum <= tgt_s) : (sum >= tgt_s);

   assign trial = {rem_ff, dvd_ff[pdfr_pkg::DUTY_W-1]};
   assign ge    = trial >= {1'b0, ticks_ff};
   assign mag   = (dvd_ff == '0) ? pdfr_pkg::DUTY_W'(1) : dvd_ff;

   always_comb begin
      duty_in   = duty_ff;
      step_in   = step_ff;
      target_in = target_ff;
      neg_in    = neg_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      if (cmd.do_tick && step_ff != '0) begin
         if (reached) begin
            duty_in = target_ff;
            step_in = '0;
         end else begin
            duty_in = sum[pdfr_pkg::DUTY_W-1:0];
         end
      end
      if (cmd.do_eval && !stat.match) begin
         if (quick_ff) begin
            duty_in   = goal_ff;
            target_in = goal_ff;
            step_in   = '0;
         end else begin
            neg_in = goal_ff < duty_ff;
            dvd_in = (goal_ff < duty_ff) ? duty_ff - goal_ff : goal_ff - duty_ff;
            rem_in = '0;
         end
      end
      if (cmd.div_step) begin
         rem_in = ge ? pdfr_pkg::TICKS_W'(trial - {1'b0, ticks_ff})
                     : trial[pdfr_pkg::TICKS_W-1:0];
         dvd_in = {dvd_ff[pdfr_pkg::DUTY_W-2:0], ge};
      end
      if (cmd.do_fin) begin
         step_in   = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
         target_in = goal_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff   <= '0;
         step_ff   <= '0;
         target_ff <= '0;
      end else begin
         duty_ff   <= duty_in;
         step_ff   <= step_in;
         target_ff <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (cmd.load) begin
         goal_ff  <= pdfr_pkg::DUTY_W'(req_dest_duty) * pdfr_pkg::DUTY_W'(pdfr_pkg::DUTY_SCALE);
         ticks_ff <= tprod[pdfr_pkg::TCK_SH +: pdfr_pkg::TICKS_W];
         quick_ff <= req_fade_time_ms <= pdfr_pkg::TIME_W'(pdfr_pkg::TICK_MS);
      end
      if (cmd.out_load) begin
         duty_out_ff <= dprod[pdfr_pkg::DSC_SH +: pdfr_pkg::DEST_W];
         fading_ff   <= step_ff != '0;
      end
   end

   assign rsp_duty_out = duty_out_ff;
   assign rsp_fading   = fading_ff;

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= pdfr_pkg::DUTY_W'(pdfr_pkg::DUTY_MAX))
      else $error("duty left its range");
   a_idle_at_target: assert property (@(posedge clock) disable iff (reset)
      step_ff == '0 && !cmd.do_fin && !cmd.do_eval |=> step_ff == '0)
      else $error("step started without a fade command");

endmodule

FILE: hdl/pdfr_ctrl.sv
// Controller of the PWM duty fade ramp: sequences tick, fade evaluation,
// serial division and the result beat. Uses pdfr_pkg.
module pdfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output pdfr_pkg::pdfr_cmd_type  cmd,
   input  pdfr_pkg::pdfr_stat_type stat
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TICK = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic [pdfr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_func ? ST_EVAL : ST_TICK;
            end
         end
         ST_TICK: begin
            cmd.do_tick = 1'b1;
            state_in    = ST_OUT;
         end
         ST_EVAL: begin
            cmd.do_eval = 1'b1;
            cnt_in      = pdfr_pkg::CNT_W'(pdfr_pkg::DUTY_W - 1);
            state_in    = (stat.match || stat.quick) ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.do_fin = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while one is in flight");
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && cnt_ff == '0 |=> state_ff == ST_FIN)
      else $error("divider overran its count");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result beat overwritten while stalled");

endmodule

FILE: hdl/pwm_duty_fade_ramp_top.sv
// A tick beat, a fade command already at target and a quick fade go from their tick or
// evaluation state straight to the result beat; any other fade command first computes
// its step in the one-bit-per-cycle restoring divider. One beat at a time: a new request
// is taken only once the result beat is loaded, which waits while a beat is stalled.
// Reset: synchronous, active high; clears duty, step and target to zero, no beat pending.
// Top level of the PWM duty fade ramp; instantiates pdfr_ctrl and pdfr_dpath.
module pwm_duty_fade_ramp_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [pdfr_pkg::DEST_W-1:0] req_dest_duty,
   input  logic [pdfr_pkg::TIME_W-1:0] req_fade_time_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pdfr_pkg::DEST_W-1:0] rsp_duty_out,
   output logic                        rsp_fading
);

   pdfr_pkg::pdfr_cmd_type  cmd;
   pdfr_pkg::pdfr_stat_type stat;

   pdfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   pdfr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_dest_duty    (req_dest_duty),
      .req_fade_time_ms (req_fade_time_ms),
      .rsp_duty_out     (rsp_duty_out),
      .rsp_fading       (rsp_fading)
   );

endmodule
